// ----- src/ipss_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// I/O permission state supervisor package
// State codes, command and register codes, widths and reset values shared by
// the supervisor.
// ----------------------------------------------------------------------------
package ipss_pkg;

  // Field widths
  localparam int ARM_W      = 4;
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int TIME_IN_W  = 32;
  localparam int MS_W       = 32;
  localparam int ALERT_W    = 16;

  // Internal arithmetic widths
  localparam int SUM_W       = TIME_IN_W + 1;
  localparam int ACC_W       = CFG_DATA_W + ALERT_W;
  localparam int PP_SPLIT    = 22;
  localparam int MS_PER_SEC  = 1000;
  localparam int MS_MUL_BITS = 10;
  localparam logic [MS_W-1:0] MS_MAX = '1;

  // Parameter defaults
  localparam int TICKS_PER_SEC_DEF = 1000;
  localparam int ALERT_CAP_SEC_DEF = 600;
  localparam int TIME_BITS_DEF     = 32;

  // Register reset values
  localparam logic [CFG_DATA_W-1:0] STAB_RST   = 32'd5000;
  localparam logic [CFG_DATA_W-1:0] UNPROT_RST = 32'd0;
  localparam logic [CFG_DATA_W-1:0] STEP_RST   = 32'd10000;

  // Permission state codes
  localparam logic [ARM_W-1:0] ARM_INIT          = 4'd0;
  localparam logic [ARM_W-1:0] ARM_IO_OFF        = 4'd1;
  localparam logic [ARM_W-1:0] ARM_BIO_OK_FIRST  = 4'd3;
  localparam logic [ARM_W-1:0] ARM_BIO_OK        = 4'd6;
  localparam logic [ARM_W-1:0] ARM_BIO_UNPROT_RO = 4'd8;
  localparam logic [ARM_W-1:0] ARM_DETACH        = 4'd9;
  localparam logic [ARM_W-1:0] ARM_DESTROYED     = 4'd10;

  // Commands
  localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SWITCH  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DESTROY = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STAB       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNPROT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RO_NEVER   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ALERT_EN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NOTIFY_EN  = 3'd5;

  // Result fields that ride along the conversion pipeline unchanged
  typedef struct packed {
    logic [ARM_W-1:0] current_arm;
    logic [ARM_W-1:0] stable_arm;
    logic             stable_changed;
    logic             alert_fire;
    logic             alert_upgrade;
    logic             readonly_due;
    logic             bad_switch;
  } res_ctl_t;

  function automatic logic has_bio(input logic [ARM_W-1:0] s);
    return s inside {[ARM_BIO_OK_FIRST:ARM_BIO_UNPROT_RO]};
  endfunction

  function automatic logic has_prot(input logic [ARM_W-1:0] s);
    return (s == ARM_BIO_OK_FIRST) || (s == ARM_BIO_OK);
  endfunction

endpackage
`default_nettype wire

// ----- src/io_permission_state_supervisor_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// I/O permission state supervisor
// Keeps a volume's permission state, its stabilized copy, outage statistics,
// the unprotected-write countdown and stuck-detach alerts.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock unless the result channel stalls,
// and returns exactly one result per transaction. All state is updated in the
// cycle a transaction is accepted; the three stages that follow only convert
// tick counts into milliseconds through a constant reciprocal multiply split
// into partial products. After a write to the alert step register the input
// is stalled while the alert threshold is recomputed by the threshold
// multiplier. Configuration writes are always taken (cfg_ready is tied high)
// and must only be issued while no transaction is in flight.
module io_permission_state_supervisor_unit #(
  parameter int TICKS_PER_SEC = ipss_pkg::TICKS_PER_SEC_DEF,
  parameter int ALERT_CAP_SEC = ipss_pkg::ALERT_CAP_SEC_DEF,
  parameter int TIME_BITS     = ipss_pkg::TIME_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [ipss_pkg::CMD_W-1:0]       in_cmd,
  input  logic [ipss_pkg::TIME_IN_W-1:0]   in_now,
  input  logic [ipss_pkg::ARM_W-1:0]       in_next_arm,
  input  logic                             in_upgrade_detach,
  // Result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [ipss_pkg::ARM_W-1:0]       out_current_arm,
  output logic [ipss_pkg::ARM_W-1:0]       out_stable_arm,
  output logic                             out_stable_changed,
  output logic                             out_alert_fire,
  output logic                             out_alert_upgrade,
  output logic [ipss_pkg::MS_W-1:0]        out_alert_elapsed_ms,
  output logic                             out_readonly_due,
  output logic [ipss_pkg::MS_W-1:0]        out_longest_outage_ms,
  output logic                             out_bad_switch,
  // Configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ipss_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ipss_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ipss_pkg::*;

  // Stored time width and saturation limit of time sums
  localparam int TW = (TIME_BITS < TIME_IN_W) ? TIME_BITS : TIME_IN_W;
  localparam logic [SUM_W-1:0] TMASK = (TIME_BITS >= SUM_W) ? {SUM_W{1'b1}} :
                                       SUM_W'((65'd1 << TIME_BITS) - 65'd1);

  localparam logic [CFG_DATA_W-1:0] ALERT_CAP = CFG_DATA_W'(ALERT_CAP_SEC * TICKS_PER_SEC);
  localparam logic [CFG_DATA_W-1:0] PER_RST   = (STEP_RST > ALERT_CAP) ? ALERT_CAP : STEP_RST;

  // ms = floor(ticks * 1000 / TICKS_PER_SEC) by an exact reciprocal multiply
  localparam int XW     = TW + MS_MUL_BITS;
  localparam int DIV_SH = XW + $clog2(TICKS_PER_SEC);
  localparam int MW     = XW + 1;
  localparam int PW     = XW + MW;
  localparam logic [63:0] RECIP =
    ((64'd1 << DIV_SH) + 64'(TICKS_PER_SEC) - 64'd1) / 64'(TICKS_PER_SEC);
  localparam int XH_W = XW - PP_SPLIT;
  localparam int MH_W = MW - PP_SPLIT;
  localparam int LL_W = 2 * PP_SPLIT;
  localparam int LH_W = PP_SPLIT + MH_W;
  localparam int HL_W = XH_W + PP_SPLIT;
  localparam int HH_W = XH_W + MH_W;
  localparam logic [PP_SPLIT-1:0] M_LO = RECIP[PP_SPLIT-1:0];
  localparam logic [MH_W-1:0]     M_HI = RECIP[MW-1:PP_SPLIT];

  function automatic logic [SUM_W-1:0] tadd(input logic [SUM_W-1:0] a,
                                            input logic [SUM_W-1:0] b);
    logic [SUM_W-1:0] s;
    s = a + b;
    return (s > TMASK) ? TMASK : s;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] cap_per(input logic [ACC_W-1:0] acc);
    return (acc > ACC_W'(ALERT_CAP)) ? ALERT_CAP : acc[CFG_DATA_W-1:0];
  endfunction

  // Configuration registers
  logic [CFG_DATA_W-1:0] stab_r, unprot_r, step_r;
  logic                  ro_never_r, alert_en_r, notify_en_r;
  logic                  pend_r;

  // Supervisor state
  logic [ARM_W-1:0]      arm_r, arm_nxt;
  logic [ARM_W-1:0]      stable_r, stable_nxt;
  logic [TW-1:0]         last_r, last_nxt;
  logic [SUM_W-1:0]      dl_r, dl_nxt;
  logic                  cd_r, cd_nxt;
  logic [ALERT_W-1:0]    alerts_r, alerts_nxt;
  logic [TW-1:0]         lo_d_r, lo_d_nxt;
  // step * (alerts + 1) and its capped form, kept so no multiply sits in the
  // transaction path
  logic [ACC_W-1:0]      acc_r, acc_nxt;
  logic [CFG_DATA_W-1:0] per_r, per_nxt;

  logic [ACC_W-1:0]      acc_plus, acc_calc;
  logic [ALERT_W:0]      alerts_inc;
  logic [TW-1:0]         now_m, elapsed;
  logic [SUM_W-1:0]      now_s, last_s;
  logic [TW-1:0]         d_alert;
  res_ctl_t              ctl_nxt;
  logic                  accept, illegal;

  // Pipeline
  logic                  v1_r, v2_r, v3_r, v4_r;
  logic                  rdy1, rdy2, rdy3, rdy4;
  res_ctl_t              ctl1_r, ctl2_r, ctl3_r, ctl4_r;
  logic [TW-1:0]         d1_r  [2];
  logic [XW-1:0]         x2_r  [2];
  logic [LL_W-1:0]       pp_ll_r [2];
  logic [LH_W-1:0]       pp_lh_r [2];
  logic [HL_W-1:0]       pp_hl_r [2];
  logic [HH_W-1:0]       pp_hh_r [2];
  logic [PW-1:0]         prod_s  [2];
  logic [PW-1:0]         quot_s  [2];
  logic [MS_W-1:0]       ms_s    [2];
  logic [MS_W-1:0]       ms4_r   [2];

  assign rdy4     = !v4_r || !out_stall;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1 || pend_r;
  assign accept   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign now_m      = in_now[TW-1:0];
  assign now_s      = SUM_W'(now_m);
  assign last_s     = SUM_W'(last_r);
  assign elapsed    = (now_m >= last_r) ? (now_m - last_r) : '0;
  assign alerts_inc = {1'b0, alerts_r} + (ALERT_W+1)'(1);
  assign acc_plus   = acc_r + ACC_W'(step_r);
  assign acc_calc   = ACC_W'(step_r) * ACC_W'(alerts_inc);

  assign illegal = (in_next_arm > ARM_DESTROYED) || (arm_r == ARM_DESTROYED) ||
                   (in_next_arm == ARM_INIT) ||
                   ((arm_r == ARM_DETACH) && has_bio(in_next_arm));

  always_comb begin
    arm_nxt    = arm_r;
    stable_nxt = stable_r;
    last_nxt   = last_r;
    dl_nxt     = dl_r;
    cd_nxt     = cd_r;
    alerts_nxt = alerts_r;
    lo_d_nxt   = lo_d_r;
    acc_nxt    = acc_r;
    per_nxt    = per_r;
    d_alert    = '0;
    ctl_nxt    = '0;
    if (accept) begin
      case (in_cmd)
        CMD_TICK: begin
          if ((stable_r != arm_r) && (tadd(last_s, SUM_W'(stab_r)) < now_s)) begin
            stable_nxt             = arm_r;
            ctl_nxt.stable_changed = notify_en_r;
          end
          if ((arm_r == ARM_DETACH) && alert_en_r &&
              (tadd(last_s, SUM_W'(per_r)) <= now_s)) begin
            ctl_nxt.alert_fire    = 1'b1;
            ctl_nxt.alert_upgrade = in_upgrade_detach;
            d_alert               = elapsed;
            if (alerts_r != '1) begin
              alerts_nxt = alerts_inc[ALERT_W-1:0];
              acc_nxt    = acc_plus;
              per_nxt    = cap_per(acc_plus);
            end
          end
        end
        CMD_SWITCH: begin
          if (in_next_arm != arm_r) begin
            if (illegal) begin
              ctl_nxt.bad_switch = 1'b1;
            end else begin
              // The outage is tracked in ticks; the ms conversion is monotonic,
              // so the maximum carries over.
              if (!has_bio(arm_r) && has_bio(in_next_arm) && (elapsed > lo_d_r)) begin
                lo_d_nxt = elapsed;
              end
              arm_nxt  = in_next_arm;
              last_nxt = now_m;
              if (has_bio(in_next_arm)) begin
                if (has_prot(in_next_arm)) begin
                  cd_nxt = 1'b0;
                  dl_nxt = '0;
                end else if (!cd_r) begin
                  cd_nxt = 1'b1;
                  dl_nxt = tadd(now_s, SUM_W'(unprot_r));
                end
              end else if (in_next_arm != ARM_IO_OFF) begin
                cd_nxt = 1'b0;
                dl_nxt = '0;
              end
            end
          end
        end
        CMD_DESTROY: begin
          arm_nxt  = ARM_DESTROYED;
          last_nxt = now_m;
        end
        CMD_CLEAR: begin
          lo_d_nxt = '0;
        end
        default: begin
        end
      endcase
    end
    if (pend_r) begin
      acc_nxt = acc_calc;
      per_nxt = cap_per(acc_calc);
    end
    ctl_nxt.current_arm  = arm_nxt;
    ctl_nxt.stable_arm   = stable_nxt;
    ctl_nxt.readonly_due = !has_prot(arm_nxt) && !ro_never_r &&
                           ((unprot_r == '0) || (cd_nxt && (dl_nxt <= now_s)));
  end

  // Configuration and supervisor state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stab_r      <= STAB_RST;
      unprot_r    <= UNPROT_RST;
      ro_never_r  <= 1'b1;
      step_r      <= STEP_RST;
      alert_en_r  <= 1'b1;
      notify_en_r <= 1'b1;
      pend_r      <= 1'b0;
      arm_r       <= ARM_INIT;
      stable_r    <= ARM_INIT;
      last_r      <= '0;
      dl_r        <= '0;
      cd_r        <= 1'b0;
      alerts_r    <= '0;
      lo_d_r      <= '0;
      acc_r       <= ACC_W'(STEP_RST);
      per_r       <= PER_RST;
    end else begin
      pend_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_STAB:      stab_r <= cfg_data;
          CFG_UNPROT:    unprot_r <= cfg_data;
          CFG_RO_NEVER:  ro_never_r <= cfg_data[0];
          CFG_STEP: begin
            step_r <= cfg_data;
            pend_r <= 1'b1;
          end
          CFG_ALERT_EN:  alert_en_r <= cfg_data[0];
          CFG_NOTIFY_EN: notify_en_r <= cfg_data[0];
          default: begin
          end
        endcase
      end
      arm_r    <= arm_nxt;
      stable_r <= stable_nxt;
      last_r   <= last_nxt;
      dl_r     <= dl_nxt;
      cd_r     <= cd_nxt;
      alerts_r <= alerts_nxt;
      lo_d_r   <= lo_d_nxt;
      acc_r    <= acc_nxt;
      per_r    <= per_nxt;
    end
  end

  // Pipeline occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= accept;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // Final stage: sum the partial products, shift and saturate.
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      prod_s[i] = (PW'(pp_hh_r[i]) << (2 * PP_SPLIT)) +
                  (PW'(pp_hl_r[i]) << PP_SPLIT) +
                  (PW'(pp_lh_r[i]) << PP_SPLIT) +
                  PW'(pp_ll_r[i]);
      quot_s[i] = prod_s[i] >> DIV_SH;
      ms_s[i]   = (quot_s[i] > PW'(MS_MAX)) ? MS_MAX : quot_s[i][MS_W-1:0];
    end
  end

  // Lane 0 carries the alert elapsed time, lane 1 the longest outage.
  always_ff @(posedge clk) begin
    if (accept) begin
      ctl1_r  <= ctl_nxt;
      d1_r[0] <= d_alert;
      d1_r[1] <= lo_d_nxt;
    end
    if (rdy2 && v1_r) begin
      ctl2_r <= ctl1_r;
      for (int i = 0; i < 2; i++) begin
        x2_r[i] <= XW'(d1_r[i]) * XW'(MS_PER_SEC);
      end
    end
    if (rdy3 && v2_r) begin
      ctl3_r <= ctl2_r;
      for (int i = 0; i < 2; i++) begin
        pp_ll_r[i] <= LL_W'(x2_r[i][PP_SPLIT-1:0]) * LL_W'(M_LO);
        pp_lh_r[i] <= LH_W'(x2_r[i][PP_SPLIT-1:0]) * LH_W'(M_HI);
        pp_hl_r[i] <= HL_W'(x2_r[i][XW-1:PP_SPLIT]) * HL_W'(M_LO);
        pp_hh_r[i] <= HH_W'(x2_r[i][XW-1:PP_SPLIT]) * HH_W'(M_HI);
      end
    end
    if (rdy4 && v3_r) begin
      ctl4_r   <= ctl3_r;
      ms4_r[0] <= ms_s[0];
      ms4_r[1] <= ms_s[1];
    end
  end

  assign out_valid             = v4_r;
  assign out_current_arm       = ctl4_r.current_arm;
  assign out_stable_arm        = ctl4_r.stable_arm;
  assign out_stable_changed    = ctl4_r.stable_changed;
  assign out_alert_fire        = ctl4_r.alert_fire;
  assign out_alert_upgrade     = ctl4_r.alert_upgrade;
  assign out_alert_elapsed_ms  = ms4_r[0];
  assign out_readonly_due      = ctl4_r.readonly_due;
  assign out_longest_outage_ms = ms4_r[1];
  assign out_bad_switch        = ctl4_r.bad_switch;

endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I/O permission state supervisor testbench
// Drives ticks, state switches, destroy and statistics-clear transactions into
// the supervisor, predicts every result with a behavioral model of the state
// machine kept alongside, and compares each returned result field by field.
// Both channels idle and stall at random; the register set is changed between
// phases, from the reset values to both extremes.
// ----------------------------------------------------------------------------
module testbench;
  import ipss_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 2_000_000;
  localparam int          DRAIN_CYCLES    = 8;
  localparam int          ZERO_STEP_TICKS = 40;
  localparam int          PHASE_ITEMS     = 355;

  localparam logic [63:0] TIME_MAX        = (64'd1 << TIME_BITS_DEF) - 64'd1;
  localparam logic [63:0] ALERT_CAP_TICKS = 64'(ALERT_CAP_SEC_DEF) * 64'(TICKS_PER_SEC_DEF);
  localparam logic [63:0] TB_TICKS_PER_SEC = 64'(TICKS_PER_SEC_DEF);
  localparam logic [63:0] TB_MS_PER_SEC    = 64'(MS_PER_SEC);
  localparam int unsigned ALERTS_MAX       = 65535;

  // Permission codes that the package leaves unnamed
  localparam logic [ARM_W-1:0] ARM_SYNC_ONLY           = 4'd2;
  localparam logic [ARM_W-1:0] ARM_BIO_UNPROT_FIRST    = 4'd4;
  localparam logic [ARM_W-1:0] ARM_BIO_UNPROT_RO_FIRST = 4'd5;
  localparam logic [ARM_W-1:0] ARM_BIO_UNPROT          = 4'd7;
  localparam logic [ARM_W-1:0] ARM_TOP_CODE            = 4'd15;

  typedef struct packed {
    logic [ARM_W-1:0] current_arm;
    logic [ARM_W-1:0] stable_arm;
    logic             stable_changed;
    logic             alert_fire;
    logic             alert_upgrade;
    logic [MS_W-1:0]  alert_ms;
    logic             readonly_due;
    logic [MS_W-1:0]  outage_ms;
    logic             bad_switch;
  } perm_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid          = 1'b0;
  logic                  in_stall;
  logic [CMD_W-1:0]      in_cmd            = '0;
  logic [TIME_IN_W-1:0]  in_now            = '0;
  logic [ARM_W-1:0]      in_next_arm       = '0;
  logic                  in_upgrade_detach = 1'b0;

  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [ARM_W-1:0]      out_current_arm;
  logic [ARM_W-1:0]      out_stable_arm;
  logic                  out_stable_changed;
  logic                  out_alert_fire;
  logic                  out_alert_upgrade;
  logic [MS_W-1:0]       out_alert_elapsed_ms;
  logic                  out_readonly_due;
  logic [MS_W-1:0]       out_longest_outage_ms;
  logic                  out_bad_switch;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Predicted registers
  logic [31:0] r_stab, r_unprot, r_step;
  logic        r_ro_never, r_alert_en, r_notify_en;

  // Predicted supervisor state
  logic [ARM_W-1:0] p_arm, p_stable;
  logic [63:0]      p_last_switch, p_deadline;
  logic             p_cd_run;
  int unsigned      p_alerts;
  logic [31:0]      p_outage;

  perm_result_t expected_q[$];
  perm_result_t chk_exp;

  logic [31:0] cur_now;
  logic        idle_on = 1'b1;
  int          rx_hold = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned stable_updates = 0;
  int unsigned alerts_predicted = 0;
  int unsigned rejected_switches = 0;

  io_permission_state_supervisor_unit dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_cmd               (in_cmd),
    .in_now               (in_now),
    .in_next_arm          (in_next_arm),
    .in_upgrade_detach    (in_upgrade_detach),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_current_arm      (out_current_arm),
    .out_stable_arm       (out_stable_arm),
    .out_stable_changed   (out_stable_changed),
    .out_alert_fire       (out_alert_fire),
    .out_alert_upgrade    (out_alert_upgrade),
    .out_alert_elapsed_ms (out_alert_elapsed_ms),
    .out_readonly_due     (out_readonly_due),
    .out_longest_outage_ms(out_longest_outage_ms),
    .out_bad_switch       (out_bad_switch),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycle_count);
      $display("io_permission_state_supervisor_unit test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic carries_bio(input logic [ARM_W-1:0] s);
    return (s >= ARM_BIO_OK_FIRST) && (s <= ARM_BIO_UNPROT_RO);
  endfunction

  function automatic logic is_protected(input logic [ARM_W-1:0] s);
    return (s == ARM_BIO_OK_FIRST) || (s == ARM_BIO_OK);
  endfunction

  function automatic logic [63:0] sat_time_add(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    return (s > TIME_MAX) ? TIME_MAX : s;
  endfunction

  // Time running backwards counts as no time at all.
  function automatic logic [31:0] ticks_to_ms(input logic [63:0] t_now, input logic [63:0] t_then);
    logic [63:0] d, ms;
    d  = (t_now >= t_then) ? t_now - t_then : 64'd0;
    ms = d * TB_MS_PER_SEC / TB_TICKS_PER_SEC;
    return (ms > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : ms[31:0];
  endfunction

  function automatic logic [63:0] alert_threshold();
    logic [63:0] per;
    per = 64'(r_step) * (64'(p_alerts) + 64'd1);
    return (per > ALERT_CAP_TICKS) ? ALERT_CAP_TICKS : per;
  endfunction

  function automatic perm_result_t predict_permission(input logic [CMD_W-1:0] cmd,
      input logic [31:0] now, input logic [ARM_W-1:0] target, input logic upg);
    perm_result_t res;
    logic [63:0]  t_now;
    logic [31:0]  gap_ms;
    logic [ARM_W-1:0] prev;
    res   = '0;
    t_now = 64'(now);
    prev  = p_arm;
    case (cmd)
      CMD_TICK: begin
        if (p_stable != p_arm && sat_time_add(p_last_switch, 64'(r_stab)) < t_now) begin
          p_stable = p_arm;
          res.stable_changed = r_notify_en;
        end
        if (p_arm == ARM_DETACH && r_alert_en &&
            sat_time_add(p_last_switch, alert_threshold()) <= t_now) begin
          res.alert_fire    = 1'b1;
          res.alert_upgrade = upg;
          res.alert_ms      = ticks_to_ms(t_now, p_last_switch);
          if (p_alerts < ALERTS_MAX) p_alerts++;
        end
      end
      CMD_SWITCH: begin
        if (target != prev) begin
          if (target > ARM_DESTROYED || prev == ARM_DESTROYED || target == ARM_INIT ||
              (prev == ARM_DETACH && carries_bio(target))) begin
            res.bad_switch = 1'b1;
          end else begin
            if (!carries_bio(prev) && carries_bio(target)) begin
              gap_ms = ticks_to_ms(t_now, p_last_switch);
              if (gap_ms > p_outage) p_outage = gap_ms;
            end
            p_arm         = target;
            p_last_switch = t_now;
            if (carries_bio(target)) begin
              if (is_protected(target)) begin
                p_cd_run   = 1'b0;
                p_deadline = '0;
              end else if (!p_cd_run) begin
                p_cd_run   = 1'b1;
                p_deadline = sat_time_add(t_now, 64'(r_unprot));
              end
            end else if (target != ARM_IO_OFF) begin
              // Going to io-off leaves a running countdown alone.
              p_cd_run   = 1'b0;
              p_deadline = '0;
            end
          end
        end
      end
      CMD_DESTROY: begin
        p_arm         = ARM_DESTROYED;
        p_last_switch = t_now;
      end
      default: p_outage = '0;
    endcase
    res.readonly_due = !is_protected(p_arm) && !r_ro_never &&
                       (r_unprot == 32'd0 || (p_cd_run && p_deadline <= t_now));
    res.current_arm = p_arm;
    res.stable_arm  = p_stable;
    res.outage_ms   = p_outage;
    return res;
  endfunction

  // ------------------------------------------------------------------ drivers

  // Mostly no pause, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(negedge clk) begin
    if (!rst_n || !idle_on) begin
      rx_hold = 0;
      out_stall <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold--;
      out_stall <= 1'b1;
    end else begin
      rx_hold = pick_gap();
      out_stall <= (rx_hold > 0);
      if (rx_hold > 0) rx_hold--;
    end
  end

  task automatic cmp_field(input string fname, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", fname, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("result transaction arrived with nothing expected");
        mismatches++;
      end else begin
        chk_exp = expected_q.pop_front();
        results_seen++;
        cmp_field("current_arm", 32'(chk_exp.current_arm), 32'(out_current_arm));
        cmp_field("stable_arm", 32'(chk_exp.stable_arm), 32'(out_stable_arm));
        cmp_field("stable_changed", 32'(chk_exp.stable_changed), 32'(out_stable_changed));
        cmp_field("alert_fire", 32'(chk_exp.alert_fire), 32'(out_alert_fire));
        cmp_field("alert_upgrade", 32'(chk_exp.alert_upgrade), 32'(out_alert_upgrade));
        cmp_field("alert_elapsed_ms", chk_exp.alert_ms, out_alert_elapsed_ms);
        cmp_field("readonly_due", 32'(chk_exp.readonly_due), 32'(out_readonly_due));
        cmp_field("longest_outage_ms", chk_exp.outage_ms, out_longest_outage_ms);
        cmp_field("bad_switch", 32'(chk_exp.bad_switch), 32'(out_bad_switch));
      end
    end
  end

  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [31:0] now,
      input logic [ARM_W-1:0] target, input logic upg);
    int gap;
    perm_result_t res;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_cmd            <= cmd;
    in_now            <= now;
    in_next_arm       <= target;
    in_upgrade_detach <= upg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    res = predict_permission(cmd, now, target, upg);
    expected_q.push_back(res);
    items_sent++;
    stable_updates    += res.stable_changed;
    alerts_predicted  += res.alert_fire;
    rejected_switches += res.bad_switch;
  endtask

  // Leaves the input idle until every outstanding result has come back.
  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_STAB:      r_stab      = data;
      CFG_UNPROT:    r_unprot    = data;
      CFG_RO_NEVER:  r_ro_never  = data[0];
      CFG_STEP:      r_step      = data;
      CFG_ALERT_EN:  r_alert_en  = data[0];
      CFG_NOTIFY_EN: r_notify_en = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_settings(input logic [31:0] stab, input logic [31:0] unprot,
      input logic ro_never, input logic [31:0] alert_step, input logic alert_en,
      input logic notify_en);
    wait_for_results();
    write_reg(CFG_STAB, stab);
    write_reg(CFG_UNPROT, unprot);
    write_reg(CFG_RO_NEVER, 32'(ro_never));
    write_reg(CFG_STEP, alert_step);
    write_reg(CFG_ALERT_EN, 32'(alert_en));
    write_reg(CFG_NOTIFY_EN, 32'(notify_en));
  endtask

  // Moves the running time forward. Steps are sized so that stabilization and
  // the current alert threshold are crossed regularly; an overflow or an
  // occasional step back makes time run backwards.
  task automatic advance_clock(input int unsigned span);
    logic [63:0] dt, nxt;
    int r;
    r = $urandom_range(0, 99);
    if (r < 60)
      dt = 64'($urandom_range(0, span));
    else if (r < 88)
      dt = 64'($urandom_range(0, 32'(alert_threshold()) + span));
    else if (r < 97)
      dt = 64'($urandom_range(0, 700_000));
    else
      dt = 64'd0;
    if (r == 99 && cur_now > span) begin
      cur_now = cur_now - $urandom_range(0, span);
    end else begin
      nxt = 64'(cur_now) + dt;
      cur_now = (nxt > TIME_MAX) ? 32'($urandom_range(0, 5000)) : nxt[31:0];
    end
  endtask

  function automatic logic [ARM_W-1:0] pick_target();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return 4'($urandom_range(32'(ARM_DESTROYED) + 1, 32'(ARM_TOP_CODE)));
    if (r < 12) return ARM_INIT;
    if (r < 17) return p_arm;
    // Destroyed is terminal, so it is kept for the last test.
    return 4'($urandom_range(32'(ARM_IO_OFF), 32'(ARM_DETACH)));
  endfunction

  // -------------------------------------------------------------------- tests

  task automatic test_directed_switching();
    send_item(CMD_TICK, 32'd0, ARM_INIT, 1'b0);
    apply_settings(32'd10, 32'd50, 1'b0, 32'd100, 1'b1, 1'b1);
    send_item(CMD_TICK, 32'd0, ARM_INIT, 1'b0);
    send_item(CMD_SWITCH, 32'd5, ARM_INIT, 1'b0);        // same state, not flagged
    send_item(CMD_SWITCH, 32'd5, ARM_TOP_CODE, 1'b1);    // target out of range
    send_item(CMD_SWITCH, 32'd10, ARM_IO_OFF, 1'b0);
    send_item(CMD_SWITCH, 32'd12, ARM_INIT, 1'b0);       // back to init is illegal
    send_item(CMD_SWITCH, 32'd1010, ARM_BIO_UNPROT, 1'b0);
    send_item(CMD_TICK, 32'd1020, ARM_INIT, 1'b0);       // period reached, not passed
    send_item(CMD_TICK, 32'd1021, ARM_INIT, 1'b0);
    send_item(CMD_SWITCH, 32'd1030, ARM_IO_OFF, 1'b0);   // countdown keeps running
    send_item(CMD_TICK, 32'd1060, ARM_INIT, 1'b0);
    send_item(CMD_SWITCH, 32'd1100, ARM_BIO_OK, 1'b0);
    send_item(CMD_SWITCH, 32'd1200, ARM_SYNC_ONLY, 1'b0);
    send_item(CMD_SWITCH, 32'd1300, ARM_DETACH, 1'b1);
    send_item(CMD_SWITCH, 32'd1350, ARM_BIO_OK_FIRST, 1'b0); // detach to bio
    send_item(CMD_TICK, 32'd1399, ARM_INIT, 1'b1);
    send_item(CMD_TICK, 32'd1400, ARM_INIT, 1'b1);
    send_item(CMD_TICK, 32'd1499, ARM_INIT, 1'b0);
    send_item(CMD_TICK, 32'd1500, ARM_INIT, 1'b0);
    send_item(CMD_CLEAR, 32'd1500, ARM_INIT, 1'b0);
    send_item(CMD_SWITCH, 32'd1000, ARM_IO_OFF, 1'b0);   // time runs backwards
    send_item(CMD_SWITCH, 32'd900, ARM_BIO_UNPROT_FIRST, 1'b0);
  endtask

  task automatic test_time_extremes();
    apply_settings('1, '1, 1'b0, '1, 1'b1, 1'b1);
    send_item(CMD_SWITCH, 32'd0, ARM_IO_OFF, 1'b0);
    send_item(CMD_SWITCH, 32'hFFFF_FFFF, ARM_BIO_UNPROT_RO_FIRST, 1'b1);
    send_item(CMD_SWITCH, 32'hFFFF_FFFF, ARM_SYNC_ONLY, 1'b0);
    send_item(CMD_SWITCH, 32'hFFFF_FFFF, ARM_BIO_UNPROT_RO, 1'b0);
    send_item(CMD_TICK, 32'hFFFF_FFFF, ARM_TOP_CODE, 1'b1);
    send_item(CMD_SWITCH, 32'd0, ARM_DETACH, 1'b1);
    send_item(CMD_TICK, 32'd599_999, ARM_INIT, 1'b1);
    send_item(CMD_TICK, 32'hFFFF_FFFF, ARM_INIT, 1'b1);
  endtask

  task automatic run_random_phase(input int count, input int unsigned span);
    int r;
    logic [CMD_W-1:0] cmd;
    logic [ARM_W-1:0] target;
    for (int i = 0; i < count; i++) begin
      advance_clock(span);
      r = $urandom_range(0, 99);
      if (r < 50) begin
        cmd    = CMD_TICK;
        target = 4'($urandom_range(0, 15));
      end else if (r < 94) begin
        cmd    = CMD_SWITCH;
        target = pick_target();
      end else begin
        cmd    = CMD_CLEAR;
        target = 4'($urandom_range(0, 15));
      end
      if ($urandom_range(0, 199) == 0) wait_for_results();
      send_item(cmd, cur_now, target, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_random_settings();
    apply_settings(32'd40, 32'd60, 1'b0, 32'd25, 1'b1, 1'b1);
    cur_now = $urandom;
    run_random_phase(PHASE_ITEMS, 30);

    idle_on = 1'b0;
    apply_settings(32'd0, 32'd0, 1'b0, 32'd1, 1'b1, 1'b0);
    cur_now = $urandom_range(0, 100_000);
    run_random_phase(PHASE_ITEMS, 8);
    idle_on = 1'b1;

    apply_settings(32'd1, 32'd1, 1'b1, 32'd7, 1'b0, 1'b1);
    run_random_phase(PHASE_ITEMS, 5);

    apply_settings('1, '1, 1'b0, '1, 1'b1, 1'b1);
    cur_now = 32'hFFFF_FFFF - $urandom_range(0, 3_000_000);
    run_random_phase(PHASE_ITEMS, 5000);

    apply_settings($urandom_range(0, 200), $urandom_range(0, 300), 1'($urandom_range(0, 1)),
                   $urandom_range(1, 50), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    cur_now = $urandom;
    run_random_phase(PHASE_ITEMS, 60);
  endtask

  // With a zero step every detaching tick alerts. A step of nine then sets a
  // new threshold from the alert count, approached from one tick below.
  task automatic test_zero_alert_step();
    logic [31:0] thr;
    idle_on = 1'b0;
    apply_settings(32'd1000, 32'd0, 1'b1, 32'd0, 1'b1, 1'b1);
    cur_now = 32'd1000;
    send_item(CMD_SWITCH, cur_now, ARM_IO_OFF, 1'b0);
    send_item(CMD_SWITCH, cur_now, ARM_DETACH, 1'b0);
    for (int i = 0; i < ZERO_STEP_TICKS; i++)
      send_item(CMD_TICK, cur_now, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
    wait_for_results();
    write_reg(CFG_STEP, 32'd9);
    thr = 32'(alert_threshold());
    send_item(CMD_TICK, cur_now + thr - 32'd1, ARM_INIT, 1'b1);
    send_item(CMD_TICK, cur_now + thr, ARM_INIT, 1'b1);
    cur_now = cur_now + thr;
    idle_on = 1'b1;
  endtask

  task automatic test_destroy();
    send_item(CMD_SWITCH, cur_now + 32'd5, ARM_DESTROYED, 1'b0);
    send_item(CMD_DESTROY, cur_now + 32'd10, ARM_INIT, 1'b0);
    send_item(CMD_SWITCH, cur_now + 32'd20, ARM_IO_OFF, 1'b0);  // nothing leaves destroyed
    send_item(CMD_TICK, cur_now + 32'd5000, ARM_INIT, 1'b0);
    send_item(CMD_CLEAR, cur_now + 32'd5000, ARM_INIT, 1'b0);
    send_item(CMD_TICK, cur_now + 32'd6000, ARM_INIT, 1'b0);
  endtask

  initial begin
    r_stab        = STAB_RST;
    r_unprot      = UNPROT_RST;
    r_ro_never    = 1'b1;
    r_step        = STEP_RST;
    r_alert_en    = 1'b1;
    r_notify_en   = 1'b1;
    p_arm         = ARM_INIT;
    p_stable      = ARM_INIT;
    p_last_switch = '0;
    p_deadline    = '0;
    p_cd_run      = 1'b0;
    p_alerts      = 0;
    p_outage      = '0;
    cur_now       = '0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_switching();
    test_time_extremes();
    test_random_settings();
    test_zero_alert_step();
    test_destroy();
    wait_for_results();

    if (expected_q.size() != 0) begin
      $error("%0d expected results never arrived", expected_q.size());
      mismatches++;
    end
    $display("Checked %0d of %0d transactions across a series of register settings in %0d cycles.",
             results_seen, items_sent, cycle_count);
    $display("Predicted %0d stable changes, %0d detach alerts and %0d rejected switches.",
             stable_updates, alerts_predicted, rejected_switches);
    if (mismatches == 0)
      $display("io_permission_state_supervisor_unit test passed");
    else
      $display("io_permission_state_supervisor_unit test failed");
    $finish;
  end

endmodule
